### rtl/core/extremum_midpoint_threshold_unit_defines.svh
// ----------------------------------------------------------------------------
// Extremum midpoint threshold unit: assertion macros
// Shared check forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef EXTREMUM_MIDPOINT_THRESHOLD_UNIT_DEFINES_SVH
`define EXTREMUM_MIDPOINT_THRESHOLD_UNIT_DEFINES_SVH

// same-cycle implication
`define EMT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define EMT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/emt_pkg.sv
// ----------------------------------------------------------------------------
// emt_pkg
// Types and constants of the extremum midpoint threshold unit.
// ----------------------------------------------------------------------------
package emt_pkg;

	localparam int PIX_W  = 8;
	localparam int IDX_W  = 11;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [PIX_W-1:0]  STEP_THR_RESET = 8'd30;
	localparam logic [ADDR_W-1:0] ADDR_STEP_THR  = 3'd0;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             line_start;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0] span_start;
		logic [IDX_W-1:0] span_end;
		logic [PIX_W-1:0] midpoint_level;
		logic             ended_at_peak;
	} span_t;

endpackage

### rtl/core/emt_if.sv
// ----------------------------------------------------------------------------
// emt_if
// Valid/ready channels for pixel beats and span beats.
// ----------------------------------------------------------------------------
interface emt_pix_if import emt_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;
	logic             line_start;

	modport source (output valid, pixel, line_start, input ready);
	modport sink   (input valid, pixel, line_start, output ready);
endinterface

interface emt_span_if import emt_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] span_start;
	logic [IDX_W-1:0] span_end;
	logic [PIX_W-1:0] midpoint_level;
	logic             ended_at_peak;

	modport source (output valid, span_start, span_end, midpoint_level, ended_at_peak,
		input ready);
	modport sink   (input valid, span_start, span_end, midpoint_level, ended_at_peak,
		output ready);
endinterface

### rtl/core/emt_track.sv
// ----------------------------------------------------------------------------
// emt_track
// Peak/valley tracker: window, candidate and row state, one pixel per step.
// ----------------------------------------------------------------------------
module emt_track import emt_pkg::*; #(
	parameter int MAX_LINE_WIDTH = 2048
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  item_t            item,
	input  logic [PIX_W-1:0] step_thr,
	output logic             hit,
	output span_t            span
);

	localparam int LW = $clog2(MAX_LINE_WIDTH + 1);
	localparam int CW = (LW > IDX_W) ? LW : IDX_W;

	logic             seek_min_q,  seek_min_d;
	logic             held_q,      held_d;
	logic [PIX_W-1:0] peak_lvl_q,  peak_lvl_d;
	logic [PIX_W-1:0] vall_lvl_q,  vall_lvl_d;
	logic [IDX_W-1:0] peak_idx_q,  peak_idx_d;
	logic [IDX_W-1:0] vall_idx_q,  vall_idx_d;
	logic [PIX_W-1:0] win0_q,      win0_d;
	logic [PIX_W-1:0] win1_q,      win1_d;
	logic [CW-1:0]    pix_idx_q,   pix_idx_d;

	logic [CW-1:0]    centre;
	logic [PIX_W:0]   lvl_sum;

	assign centre = pix_idx_q - CW'(1);

	always_comb begin
		seek_min_d = seek_min_q;
		held_d     = held_q;
		peak_lvl_d = peak_lvl_q;
		vall_lvl_d = vall_lvl_q;
		peak_idx_d = peak_idx_q;
		vall_idx_d = vall_idx_q;
		win0_d     = win0_q;
		win1_d     = win1_q;
		pix_idx_d  = pix_idx_q;
		hit        = 1'b0;
		span       = '0;
		lvl_sum    = '0;

		if (item.line_start) begin
			seek_min_d = 1'b0;
			held_d     = 1'b0;
			peak_lvl_d = item.pixel;
			vall_lvl_d = '0;
			peak_idx_d = '0;
			vall_idx_d = '0;
			win0_d     = '0;
			win1_d     = item.pixel;
			pix_idx_d  = CW'(1);
		end else if (pix_idx_q < CW'(MAX_LINE_WIDTH)) begin
			if (pix_idx_q >= CW'(2)) begin
				if (!seek_min_q) begin
					if (win1_q > win0_q && win1_q > item.pixel) begin
						if (!held_q || win1_q > peak_lvl_q) begin
							peak_lvl_d = win1_q;
							peak_idx_d = centre[IDX_W-1:0];
						end
						held_d = 1'b1;
						if (win1_q - item.pixel > step_thr) begin
							seek_min_d = 1'b1;
							held_d     = 1'b0;
							hit        = 1'b1;
						end
					end
				end else begin
					if (win1_q < win0_q && win1_q < item.pixel) begin
						if (!held_q || win1_q < vall_lvl_q) begin
							vall_lvl_d = win1_q;
							vall_idx_d = centre[IDX_W-1:0];
						end
						held_d = 1'b1;
						if (item.pixel - win1_q > step_thr) begin
							seek_min_d = 1'b0;
							held_d     = 1'b0;
							hit        = 1'b1;
						end
					end
				end
			end
			win0_d    = win1_q;
			win1_d    = item.pixel;
			pix_idx_d = pix_idx_q + CW'(1);
		end

		// span reports the levels and indices as updated by this pixel
		lvl_sum             = {1'b0, peak_lvl_d} + {1'b0, vall_lvl_d};
		span.midpoint_level = lvl_sum[PIX_W:1];
		span.ended_at_peak  = !seek_min_q;
		if (!seek_min_q) begin
			span.span_start = vall_idx_d + IDX_W'(1);
			span.span_end   = peak_idx_d;
		end else begin
			span.span_start = peak_idx_d + IDX_W'(1);
			span.span_end   = vall_idx_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seek_min_q <= 1'b0;
			held_q     <= 1'b0;
			peak_lvl_q <= '0;
			vall_lvl_q <= '0;
			peak_idx_q <= '0;
			vall_idx_q <= '0;
			win0_q     <= '0;
			win1_q     <= '0;
			pix_idx_q  <= '0;
		end else if (step_en) begin
			seek_min_q <= seek_min_d;
			held_q     <= held_d;
			peak_lvl_q <= peak_lvl_d;
			vall_lvl_q <= vall_lvl_d;
			peak_idx_q <= peak_idx_d;
			vall_idx_q <= vall_idx_d;
			win0_q     <= win0_d;
			win1_q     <= win1_d;
			pix_idx_q  <= pix_idx_d;
		end
	end

endmodule

### rtl/core/extremum_midpoint_threshold_unit.sv
// Path: a pixel beat is taken into the input register, then the tracker logic loads
//   any confirmed span into the output register.
// Throughput: one pixel per cycle unless a waiting span meets a low span_out.ready.
// While a span waits in the output register the input stage holds one beat, then stalls.
// Reset (arst_n low, asynchronous): pipeline empty, tracker state cleared,
//   step_threshold back to 30.
// ----------------------------------------------------------------------------
// extremum_midpoint_threshold_unit
// Row-wise peak/valley tracker that emits spans with a midpoint threshold.
// ----------------------------------------------------------------------------
`include "extremum_midpoint_threshold_unit_defines.svh"

module extremum_midpoint_threshold_unit import emt_pkg::*; #(
	parameter int MAX_LINE_WIDTH = 2048
) (
	input  logic              clk,
	input  logic              arst_n,
	emt_pix_if.sink           pix_in,
	emt_span_if.source        span_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	logic [PIX_W-1:0] step_thr_q;
	item_t            item_s1;
	logic             valid_s1;
	span_t            span_q;
	logic             span_valid_q;
	logic             adv;
	logic             in_acc;
	logic             hit;
	span_t            span_d;

	// ---- config port ----
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_STEP_THR) ? DATA_W'(step_thr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_thr_q <= STEP_THR_RESET;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_STEP_THR) begin
			step_thr_q <= pwdata[PIX_W-1:0];
		end
	end

	// ---- input stage ----
	assign adv          = valid_s1 && (!span_valid_q || span_out.ready);
	assign pix_in.ready = !valid_s1 || adv;
	assign in_acc       = pix_in.valid && pix_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.pixel      <= pix_in.pixel;
			item_s1.line_start <= pix_in.line_start;
		end
	end

	emt_track #(
		.MAX_LINE_WIDTH (MAX_LINE_WIDTH)
	) u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (adv),
		.item     (item_s1),
		.step_thr (step_thr_q),
		.hit      (hit),
		.span     (span_d)
	);

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_valid_q <= 1'b0;
		end else if (adv && hit) begin
			span_valid_q <= 1'b1;
		end else if (span_out.ready) begin
			span_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && hit) begin
			span_q <= span_d;
		end
	end

	assign span_out.valid          = span_valid_q;
	assign span_out.span_start     = span_q.span_start;
	assign span_out.span_end       = span_q.span_end;
	assign span_out.midpoint_level = span_q.midpoint_level;
	assign span_out.ended_at_peak  = span_q.ended_at_peak;

	// ---- checks ----
	`EMT_ASSERT_NOW(a_no_span_on_line_start, valid_s1 && item_s1.line_start, !hit,
		"line start beat produced a span")
	`EMT_ASSERT_NOW(a_ready_when_out_free, !span_valid_q, pix_in.ready,
		"input stalled with empty output register")
	`EMT_ASSERT_NEXT(a_s1_holds_on_stall, valid_s1 && !adv,
		valid_s1 && $stable(item_s1), "stalled input stage lost its beat")
	`EMT_ASSERT_NEXT(a_span_loaded, adv && hit, span_valid_q,
		"confirmed span not loaded into output register")

endmodule
